>>> hw/rtl/abp_pkg.sv
package abp_pkg;

  localparam int unsigned VersionWidth  = 32;
  localparam int unsigned AttemptsWidth = 8;
  localparam logic [AttemptsWidth-1:0] MaxTrialAttemptsReset = 8'd3;

  // Slot codes as they appear on slot_id, decision_slot and pending_now.
  localparam logic [1:0] SLOT_A    = 2'd0;
  localparam logic [1:0] SLOT_B    = 2'd1;
  localparam logic [1:0] SLOT_NONE = 2'd2;

  typedef enum logic [1:0] {
    REQ_STAGE   = 2'd0,
    REQ_SELECT  = 2'd1,
    REQ_CONFIRM = 2'd2
  } req_kind_e;

  typedef enum logic [2:0] {
    DEC_NONE      = 3'd0,
    DEC_TRIAL     = 3'd1,
    DEC_CONFIRMED = 3'd2,
    DEC_FALLBACK  = 3'd3,
    DEC_RECOVERY  = 3'd4
  } dec_kind_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [1:0]              slot_id;
    logic                    a_present;
    logic                    a_auth;
    logic [VersionWidth-1:0] a_version;
    logic                    b_present;
    logic                    b_auth;
    logic [VersionWidth-1:0] b_version;
  } req_t;

  typedef struct packed {
    logic                     accepted;
    logic [1:0]               decision_slot;
    logic [2:0]               decision_kind;
    logic                     trial_updated;
    logic                     confirmed_now;
    logic [1:0]               pending_now;
    logic [AttemptsWidth-1:0] attempts_now;
    logic [VersionWidth-1:0]  min_version_now;
  } rsp_t;

  // Handshake between a pipeline register and the stage after it.
  typedef struct packed {
    logic valid;
    logic take;
  } hs_t;

endpackage

>>> hw/rtl/ab_boot_slot_policy.sv
// A/B boot slot policy. Each request transaction (stage, select or confirm)
// is captured in an input register, evaluated against the stored policy state
// (confirmed slot, pending trial slot, trial attempts used and anti-rollback
// minimum version) in one short pass of compare logic, and its single result
// transaction lands in an output register. The policy state is updated in the
// same cycle the result is registered, so the next request already sees it.
// Throughput is one request per clock while out_stall_i is low. out_valid_o
// rises as a request enters the output register; the input register keeps
// taking requests while a result waits under out_stall_i until both are full.
// The max_trial_attempts register (reset value 3) is written through the
// cfg_valid_i/cfg_ready_o channel, which is always ready; write it only while
// no request is in flight. A select with a maximum of zero answers none and
// leaves the state untouched.
module ab_boot_slot_policy #(
  parameter logic [abp_pkg::AttemptsWidth-1:0] MaxTrialAttemptsReset =
    abp_pkg::MaxTrialAttemptsReset
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [abp_pkg::AttemptsWidth-1:0]   cfg_wdata_i,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          req_type_i,
  input  logic [1:0]                          slot_id_i,
  input  logic                                slot_a_present_i,
  input  logic                                slot_a_authenticated_i,
  input  logic [abp_pkg::VersionWidth-1:0]    slot_a_version_i,
  input  logic                                slot_b_present_i,
  input  logic                                slot_b_authenticated_i,
  input  logic [abp_pkg::VersionWidth-1:0]    slot_b_version_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                accepted_o,
  output logic [1:0]                          decision_slot_o,
  output logic [2:0]                          decision_kind_o,
  output logic                                trial_updated_o,
  output logic                                confirmed_now_o,
  output logic [1:0]                          pending_now_o,
  output logic [abp_pkg::AttemptsWidth-1:0]   attempts_now_o,
  output logic [abp_pkg::VersionWidth-1:0]    min_version_now_o
);

  logic [abp_pkg::AttemptsWidth-1:0] max_att_q;
  abp_pkg::req_t req_in, req_s1;
  abp_pkg::rsp_t rsp_s1, rsp_out;
  abp_pkg::hs_t  hs_s1;
  logic          take;
  logic          fire;

  // The configuration register never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q <= MaxTrialAttemptsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_att_q <= cfg_wdata_i;
    end
  end

  assign req_in.req_type  = req_type_i;
  assign req_in.slot_id   = slot_id_i;
  assign req_in.a_present = slot_a_present_i;
  assign req_in.a_auth    = slot_a_authenticated_i;
  assign req_in.a_version = slot_a_version_i;
  assign req_in.b_present = slot_b_present_i;
  assign req_in.b_auth    = slot_b_authenticated_i;
  assign req_in.b_version = slot_b_version_i;

  abp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (req_in),
    .take_i     (take),
    .hs_o       (hs_s1),
    .req_o      (req_s1)
  );

  // A request is evaluated, and the state committed, when it moves from the
  // input register into the result register.
  assign fire = hs_s1.valid && hs_s1.take;

  abp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .req_i     (req_s1),
    .max_att_i (max_att_q),
    .rsp_o     (rsp_s1)
  );

  abp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (hs_s1.valid),
    .take_o      (take),
    .rsp_i       (rsp_s1),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rsp_o       (rsp_out)
  );

  assign accepted_o        = rsp_out.accepted;
  assign decision_slot_o   = rsp_out.decision_slot;
  assign decision_kind_o   = rsp_out.decision_kind;
  assign trial_updated_o   = rsp_out.trial_updated;
  assign confirmed_now_o   = rsp_out.confirmed_now;
  assign pending_now_o     = rsp_out.pending_now;
  assign attempts_now_o    = rsp_out.attempts_now;
  assign min_version_now_o = rsp_out.min_version_now;

endmodule

>>> hw/rtl/abp_in_reg.sv
module abp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  abp_pkg::req_t req_i,
  input  logic          take_i,
  output abp_pkg::hs_t  hs_o,
  output abp_pkg::req_t req_o
);

  logic          valid_q, valid_d;
  logic          load;
  abp_pkg::req_t req_q;

  // The register can load when empty or when its transaction moves on.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign hs_o.valid = valid_q;
  assign hs_o.take  = take_i;
  assign req_o      = req_q;

endmodule

>>> hw/rtl/abp_core.sv
module abp_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  abp_pkg::req_t                         req_i,
  input  logic [abp_pkg::AttemptsWidth-1:0]     max_att_i,
  output abp_pkg::rsp_t                         rsp_o
);

  logic                                conf_q, conf_d;
  logic [1:0]                          pend_q, pend_d;
  logic [abp_pkg::AttemptsWidth-1:0]   att_q, att_d;
  logic [abp_pkg::VersionWidth-1:0]    minv_q, minv_d;

  logic [1:0]                          elig;
  logic                                sid_valid;
  logic                                sid_bit;
  logic [abp_pkg::VersionWidth-1:0]    sid_ver;
  abp_pkg::rsp_t                       rsp;

  // A slot is eligible when present, authenticated and not rolled back.
  assign elig[0] = req_i.a_present && req_i.a_auth && (req_i.a_version >= minv_q);
  assign elig[1] = req_i.b_present && req_i.b_auth && (req_i.b_version >= minv_q);

  assign sid_valid = !req_i.slot_id[1];
  assign sid_bit   = req_i.slot_id[0];
  assign sid_ver   = sid_bit ? req_i.b_version : req_i.a_version;

  always_comb begin
    conf_d = conf_q;
    pend_d = pend_q;
    att_d  = att_q;
    minv_d = minv_q;
    rsp    = '0;
    rsp.decision_slot = abp_pkg::SLOT_NONE;
    rsp.decision_kind = abp_pkg::DEC_NONE;

    unique case (req_i.req_type)
      abp_pkg::REQ_STAGE: begin
        if (sid_valid && (sid_bit != conf_q) && elig[sid_bit]) begin
          pend_d       = req_i.slot_id;
          att_d        = '0;
          rsp.accepted = 1'b1;
        end
      end
      abp_pkg::REQ_SELECT: begin
        if (max_att_i != '0) begin
          if (!pend_q[1] && elig[pend_q[0]] && (att_q < max_att_i)) begin
            att_d             = att_q + 8'd1;
            rsp.decision_slot = pend_q;
            rsp.decision_kind = abp_pkg::DEC_TRIAL;
            rsp.trial_updated = 1'b1;
          end else begin
            if (pend_q != abp_pkg::SLOT_NONE) begin
              pend_d            = abp_pkg::SLOT_NONE;
              att_d             = '0;
              rsp.trial_updated = 1'b1;
            end
            if (elig[conf_q]) begin
              rsp.decision_slot = {1'b0, conf_q};
              rsp.decision_kind = rsp.trial_updated ? abp_pkg::DEC_FALLBACK
                                                    : abp_pkg::DEC_CONFIRMED;
            end else if (elig[!conf_q]) begin
              rsp.decision_slot = {1'b0, !conf_q};
              rsp.decision_kind = abp_pkg::DEC_RECOVERY;
            end
          end
        end
      end
      abp_pkg::REQ_CONFIRM: begin
        if (sid_valid && elig[sid_bit] &&
            ((sid_bit == conf_q) || (req_i.slot_id == pend_q))) begin
          conf_d       = sid_bit;
          pend_d       = abp_pkg::SLOT_NONE;
          att_d        = '0;
          rsp.accepted = 1'b1;
          if (sid_ver > minv_q) begin
            minv_d = sid_ver;
          end
        end
      end
      default: begin
        // The unused request code leaves everything alone.
      end
    endcase

    rsp.confirmed_now   = conf_d;
    rsp.pending_now     = pend_d;
    rsp.attempts_now    = att_d;
    rsp.min_version_now = minv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= 1'b0;
      pend_q <= abp_pkg::SLOT_NONE;
      att_q  <= '0;
      minv_q <= '0;
    end else if (fire_i) begin
      conf_q <= conf_d;
      pend_q <= pend_d;
      att_q  <= att_d;
      minv_q <= minv_d;
    end
  end

  assign rsp_o = rsp;

  a_pend_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q[1] && pend_q[0]))
    else $error("pending slot holds the unused code");

  a_att_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == abp_pkg::SLOT_NONE) |-> (att_q == '0))
    else $error("attempt count nonzero without a pending slot");

  a_minv_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (minv_q >= $past(minv_q)))
    else $error("minimum version went down");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable({conf_q, pend_q, att_q, minv_q}))
    else $error("policy state changed without a transaction");

endmodule

>>> hw/rtl/abp_out_reg.sv
module abp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          take_o,
  input  abp_pkg::rsp_t rsp_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output abp_pkg::rsp_t rsp_o
);

  logic          valid_q;
  abp_pkg::rsp_t rsp_q;

  // The result register refills whenever its content is gone or leaving.
  assign take_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule
